FILE: rtl/core/mhpq_pkg.sv
// shared types and constants for the min-heap priority queue
// used by the channel interfaces, the controller, the datapath and the top level
package mhpq_pkg;

   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;

   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_START,
      OP_UP,
      OP_DN_LOAD,
      OP_DN,
      OP_RESP
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic single;
      logic up_done;
      logic dn_done;
   } sts_type;

endpackage

FILE: rtl/core/mhpq_req_if.sv
// request channel: one push or pop word per handshake
// depends on mhpq_pkg for the payload widths
interface mhpq_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic signed [mhpq_pkg::DATA_W-1:0]  value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

FILE: rtl/core/mhpq_rsp_if.sv
// response channel: one result word per handshake
// depends on mhpq_pkg for the payload widths
interface mhpq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [mhpq_pkg::DATA_W-1:0]    top_value;
   logic                                  is_empty;
   logic        [mhpq_pkg::COUNT_W-1:0]   entry_count;
   logic        [mhpq_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output top_value, output is_empty, output entry_count,
                   output status, input ready);
   modport sink   (input valid, input top_value, input is_empty, input entry_count,
                   input status, output ready);
endinterface

FILE: rtl/core/min_heap_priority_queue.sv
// min-heap priority queue: one push or pop word in, one result word out
// push: start, sift-up per level climbed, finish; pop: start, root load, sift-down
// per level descended, finish; one tree level per cycle, set by the single write
// port of the heap store; one word in flight; result registered when output frees
// synchronous reset empties the queue at once; store contents stay undefined
module min_heap_priority_queue #(
   parameter int CAPACITY  = 256,
   parameter int KEY_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   mhpq_req_if.sink    req_bus,
   mhpq_rsp_if.source  rsp_bus
);

   mhpq_pkg::cmd_type cmd;
   mhpq_pkg::sts_type sts;

   mhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_ready  (req_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mhpq_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .in_action       (req_bus.action),
      .in_value        (req_bus.value),
      .sts             (sts),
      .out_top_value   (rsp_bus.top_value),
      .out_is_empty    (rsp_bus.is_empty),
      .out_entry_count (rsp_bus.entry_count),
      .out_status      (rsp_bus.status)
   );

endmodule

FILE: rtl/core/mhpq_datapath.sv
// heap store, sift registers, compare logic and result register
// depends on mhpq_pkg for command, status and code definitions
module mhpq_datapath #(
   parameter int CAPACITY  = 256,
   parameter int KEY_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mhpq_pkg::cmd_type                     cmd,
   input  logic                                  in_action,
   input  logic signed [mhpq_pkg::DATA_W-1:0]    in_value,
   output mhpq_pkg::sts_type                     sts,
   output logic signed [mhpq_pkg::DATA_W-1:0]    out_top_value,
   output logic                                  out_is_empty,
   output logic        [mhpq_pkg::COUNT_W-1:0]   out_entry_count,
   output logic        [mhpq_pkg::STATUS_W-1:0]  out_status
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = IDX_W + 2;
   localparam int RAW_W = (KEY_WIDTH > mhpq_pkg::DATA_W) ? KEY_WIDTH : mhpq_pkg::DATA_W;

   logic [KEY_WIDTH-1:0] heap_mem [CAPACITY];

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [KEY_WIDTH-1:0] moving_ff, moving_in;
   logic [KEY_WIDTH-1:0] top_ff;
   logic [mhpq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [KEY_WIDTH-1:0] rd_a_ff, rd_b_ff;

   logic signed [mhpq_pkg::DATA_W-1:0]  out_top_ff;
   logic                                out_empty_ff;
   logic [mhpq_pkg::COUNT_W-1:0]        out_count_ff;
   logic [mhpq_pkg::STATUS_W-1:0]       out_status_ff;

   logic                 wr_en, rd_en;
   logic [IDX_W-1:0]     wr_addr, rd_a_addr, rd_b_addr;
   logic [KEY_WIDTH-1:0] wr_data;

   logic [RAW_W-1:0]     raw_value, top_ext;
   logic [KEY_WIDTH-1:0] in_key;
   logic                 full, empty;

   logic [IDX_W-1:0]     up_parent, up_grand;
   logic                 up_swap;

   logic [EXT_W-1:0]     kid_l, kid_r, kid_sel, n_ext;
   logic                 has_l, has_r, pick_r, dn_swap;
   logic [KEY_WIDTH-1:0] kid_key;
   logic [IDX_W-1:0]     kid_idx, next_l, next_r;

   // key is the low KEY_WIDTH bits of the word, sign taken from the key's own top bit
   assign raw_value = RAW_W'($unsigned(in_value));
   assign in_key    = raw_value[KEY_WIDTH-1:0];
   assign top_ext   = RAW_W'($signed(top_ff));

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   assign up_parent = (pos_ff - IDX_W'(1)) >> 1;
   assign up_grand  = (up_parent - IDX_W'(1)) >> 1;
   assign up_swap   = (pos_ff != '0) && ($signed(rd_a_ff) > $signed(moving_ff));

   assign kid_l   = {1'b0, pos_ff, 1'b1};
   assign kid_r   = kid_l + EXT_W'(1);
   assign n_ext   = EXT_W'(count_ff);
   assign has_l   = kid_l < n_ext;
   assign has_r   = kid_r < n_ext;
   // left child wins a tie
   assign pick_r  = has_r && ($signed(rd_a_ff) > $signed(rd_b_ff));
   assign kid_key = pick_r ? rd_b_ff : rd_a_ff;
   assign kid_sel = pick_r ? kid_r : kid_l;
   assign dn_swap = has_l && ($signed(kid_key) < $signed(moving_ff));
   assign kid_idx = kid_sel[IDX_W-1:0];
   assign next_l  = IDX_W'({kid_idx, 1'b1});
   assign next_r  = next_l + IDX_W'(1);

   assign sts.full    = full;
   assign sts.empty   = empty;
   assign sts.single  = (count_ff == CNT_W'(1));
   assign sts.up_done = !up_swap;
   assign sts.dn_done = !dn_swap;

   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      moving_in = moving_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = moving_ff;
      rd_en     = 1'b0;
      rd_a_addr = '0;
      rd_b_addr = '0;
      unique case (cmd.op)
         mhpq_pkg::OP_START: begin
            if (in_action == mhpq_pkg::ACTION_PUSH) begin
               if (full) begin
                  status_in = mhpq_pkg::STATUS_FULL;
               end else begin
                  status_in = mhpq_pkg::STATUS_OK;
                  pos_in    = IDX_W'(count_ff);
                  moving_in = in_key;
                  count_in  = count_ff + CNT_W'(1);
                  rd_en     = 1'b1;
                  rd_a_addr = IDX_W'((count_ff - CNT_W'(1)) >> 1);
               end
            end else begin
               if (empty) begin
                  status_in = mhpq_pkg::STATUS_EMPTY;
               end else begin
                  status_in = mhpq_pkg::STATUS_OK;
                  count_in  = count_ff - CNT_W'(1);
                  rd_en     = 1'b1;
                  rd_a_addr = IDX_W'(count_ff - CNT_W'(1));
               end
            end
         end
         mhpq_pkg::OP_UP: begin
            wr_en = 1'b1;
            if (up_swap) begin
               wr_data   = rd_a_ff;
               pos_in    = up_parent;
               rd_en     = 1'b1;
               rd_a_addr = up_grand;
            end
         end
         mhpq_pkg::OP_DN_LOAD: begin
            moving_in = rd_a_ff;
            pos_in    = '0;
            rd_en     = 1'b1;
            rd_a_addr = IDX_W'(1);
            rd_b_addr = IDX_W'(2);
         end
         mhpq_pkg::OP_DN: begin
            wr_en = 1'b1;
            if (dn_swap) begin
               wr_data   = kid_key;
               pos_in    = kid_idx;
               rd_en     = 1'b1;
               rd_a_addr = next_l;
               rd_b_addr = next_r;
            end
         end
         mhpq_pkg::OP_NONE, mhpq_pkg::OP_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= heap_mem[rd_a_addr];
         rd_b_ff <= heap_mem[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // root mirror saves a read when the result goes out
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      moving_ff <= moving_in;
      status_ff <= status_in;
      if (wr_en && (wr_addr == '0)) begin
         top_ff <= wr_data;
      end
      if (cmd.op == mhpq_pkg::OP_RESP) begin
         out_top_ff    <= empty ? '0 : top_ext[mhpq_pkg::DATA_W-1:0];
         out_empty_ff  <= empty;
         out_count_ff  <= mhpq_pkg::COUNT_W'(count_ff);
         out_status_ff <= status_ff;
      end
   end

   assign out_top_value   = out_top_ff;
   assign out_is_empty    = out_empty_ff;
   assign out_entry_count = out_count_ff;
   assign out_status      = out_status_ff;

endmodule

FILE: rtl/core/mhpq_ctrl.sv
// sequencer for push sift-up and pop sift-down, plus response handshake
// depends on mhpq_pkg for command and status definitions
module mhpq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_action,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  mhpq_pkg::sts_type  sts,
   output mhpq_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_UP      = 3'd1;
   localparam logic [2:0] S_DN_LOAD = 3'd2;
   localparam logic [2:0] S_DN      = 3'd3;
   localparam logic [2:0] S_FINISH  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = mhpq_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = mhpq_pkg::OP_START;
               if (req_action == mhpq_pkg::ACTION_PUSH) begin
                  state_in = sts.full ? S_FINISH : S_UP;
               end else begin
                  // a pop that leaves nothing needs no sift
                  state_in = (sts.empty || sts.single) ? S_FINISH : S_DN_LOAD;
               end
            end
         end
         S_UP: begin
            cmd.op = mhpq_pkg::OP_UP;
            if (sts.up_done) begin
               state_in = S_FINISH;
            end
         end
         S_DN_LOAD: begin
            cmd.op   = mhpq_pkg::OP_DN_LOAD;
            state_in = S_DN;
         end
         S_DN: begin
            cmd.op = mhpq_pkg::OP_DN;
            if (sts.dn_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = mhpq_pkg::OP_RESP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
